### src/qte_pkg.sv
// types, constants and helper functions for the quaternion to euler angle core
// no dependencies
package qte_pkg;

    localparam int TERM_W   = 34;   // q.29 matrix terms, signed
    localparam int CORDIC_W = 36;   // cordic x/y datapath, signed
    localparam int ATAN_LEN = 24;

    localparam logic signed [TERM_W-1:0] ONE_Q29 = TERM_W'(64'sd1 << 29);

    typedef struct packed {
        logic signed [TERM_W-1:0] m31;
        logic signed [TERM_W-1:0] m32;
        logic signed [TERM_W-1:0] m33;
        logic signed [TERM_W-1:0] m12;
        logic signed [TERM_W-1:0] m22;
        logic signed [TERM_W-1:0] m11;
        logic signed [TERM_W-1:0] m21;
    } terms_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } sqrt_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [31:0]                acc;
        logic                       zero;
    } lane_t;

    typedef struct packed {
        lane_t pitch;
        lane_t yaw;
        lane_t roll;
        logic  gimbal;
    } cstage_t;

    // arctangent of 2^-i in units of 2^-32 turns, truncated
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0:       t = 32'h20000000;
            1:       t = 32'h12E4051E;
            2:       t = 32'h09FB385B;
            3:       t = 32'h051111D4;
            4:       t = 32'h028B0D43;
            5:       t = 32'h0145D7E1;
            6:       t = 32'h00A2F61E;
            7:       t = 32'h00517C55;
            8:       t = 32'h0028BE53;
            9:       t = 32'h00145F2F;
            10:      t = 32'h000A2F98;
            11:      t = 32'h000517CC;
            12:      t = 32'h00028BE6;
            13:      t = 32'h000145F3;
            14:      t = 32'h0000A2F9;
            15:      t = 32'h0000517C;
            16:      t = 32'h000028BE;
            17:      t = 32'h0000145F;
            18:      t = 32'h00000A2F;
            19:      t = 32'h00000517;
            20:      t = 32'h0000028B;
            21:      t = 32'h00000145;
            22:      t = 32'h000000A2;
            23:      t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    // vector folded into the right half plane, pi added when x was negative
    function automatic lane_t lane_prep(input logic signed [CORDIC_W-1:0] y,
                                        input logic signed [CORDIC_W-1:0] x);
        lane_t l;
        l.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            l.x   = -x;
            l.y   = -y;
            l.acc = 32'h8000_0000;
        end
        else
        begin
            l.x   = x;
            l.y   = y;
            l.acc = 32'h0;
        end
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l, input int i);
        lane_t o;
        o = l;
        if (l.y >= 0)
        begin
            o.x   = l.x + (l.y >>> i);
            o.y   = l.y - (l.x >>> i);
            o.acc = l.acc + atan_turn(i);
        end
        else
        begin
            o.x   = l.x - (l.y >>> i);
            o.y   = l.y + (l.x >>> i);
            o.acc = l.acc - atan_turn(i);
        end
        return o;
    endfunction

    // round half up to a 16-bit binary angle
    function automatic logic [15:0] lane_angle(input lane_t l);
        logic [31:0] s;
        s = l.acc + 32'h0000_8000;
        return l.zero ? 16'h0 : s[31:16];
    endfunction

endpackage

### src/quaternion_to_euler_angles_core.sv
// quaternion to euler angle (zxy) conversion, fully pipelined
// depends on qte_pkg
// throughput: one quaternion per cycle while the output is not stalled; the
//   32-stage square-root pipeline and the CORDIC_STEPS cordic stages each do
//   one step per register stage
// a stall at the output freezes every stage at once
// reset clears all valid bits and sets gimbal_threshold to 1
module quaternion_to_euler_angles_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS   = 16,
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      gimbal_threshold_we,
    input  logic [15:0]               gimbal_threshold_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, zero fill
    input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // pitch_angle, yaw_angle, roll_angle
    output logic [47:0]               m_axis_tdata,
    // gimbal_lock
    output logic [0:0]                m_axis_tuser
);

    localparam int CB  = COMPONENT_BITS;
    localparam int PW  = 2 * CB;
    localparam int SHR = (PW >= 32) ? PW - 32 : 0;
    localparam int SHL = (PW < 32) ? 32 - PW : 0;
    localparam int NSQ = 32;

    function automatic logic signed [31:0] prod30(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b);
        logic signed [PW-1:0] p;
        p = a * b;
        return 32'(p >>> SHR) <<< SHL;
    endfunction

    logic en;
    logic [15:0] gimbal_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gimbal_threshold_reg <= 16'd1;
        else if (gimbal_threshold_we)
            gimbal_threshold_reg <= gimbal_threshold_wdata;
    end

    // stage a: input capture
    logic va_reg;
    logic signed [CB-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    // stage b: products
    logic vb_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    // stage c: matrix terms
    logic vc_reg;
    terms_t tc_reg, tc_next;
    // stage d: squares
    logic vd_reg;
    terms_t td_reg;
    logic [63:0] sq33_reg, sq31_reg;
    logic [31:0] mag33, mag31;
    // square root pipeline, index 0 holds the sum
    logic   sv_reg [0:NSQ];
    terms_t st_reg [0:NSQ];
    sqrt_t  sq_reg [0:NSQ];
    // cordic pipeline, index 0 holds the prepared operands
    logic    cv_reg [0:CORDIC_STEPS];
    cstage_t cs_reg [0:CORDIC_STEPS];
    cstage_t prep_next;
    // output register
    logic out_v_reg;
    logic [47:0] out_data_reg, out_data_next;
    logic out_gimbal_reg;

    assign en            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            sv_reg[0] <= 1'b0;
            cv_reg[0] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg    <= s_axis_tvalid;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            vd_reg    <= vc_reg;
            sv_reg[0] <= vd_reg;
            cv_reg[0] <= sv_reg[NSQ];
            out_v_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_comb
    begin
        tc_next.m31 = TERM_W'(xz_reg) + TERM_W'(yw_reg);
        tc_next.m32 = TERM_W'(yz_reg) - TERM_W'(xw_reg);
        tc_next.m33 = ONE_Q29 - TERM_W'(xx_reg) - TERM_W'(yy_reg);
        tc_next.m12 = TERM_W'(xy_reg) + TERM_W'(zw_reg);
        tc_next.m22 = ONE_Q29 - TERM_W'(xx_reg) - TERM_W'(zz_reg);
        tc_next.m11 = ONE_Q29 - TERM_W'(yy_reg) - TERM_W'(zz_reg);
        tc_next.m21 = TERM_W'(xy_reg) - TERM_W'(zw_reg);
        mag33 = (tc_reg.m33 < 0) ? 32'(-tc_reg.m33) : 32'(tc_reg.m33);
        mag31 = (tc_reg.m31 < 0) ? 32'(-tc_reg.m31) : 32'(tc_reg.m31);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= s_axis_tdata[CB-1:0];
            qy_reg <= s_axis_tdata[2*CB-1:CB];
            qz_reg <= s_axis_tdata[3*CB-1:2*CB];
            qw_reg <= s_axis_tdata[4*CB-1:3*CB];
            xx_reg <= prod30(qx_reg, qx_reg);
            yy_reg <= prod30(qy_reg, qy_reg);
            zz_reg <= prod30(qz_reg, qz_reg);
            xy_reg <= prod30(qx_reg, qy_reg);
            xz_reg <= prod30(qx_reg, qz_reg);
            yz_reg <= prod30(qy_reg, qz_reg);
            xw_reg <= prod30(qx_reg, qw_reg);
            yw_reg <= prod30(qy_reg, qw_reg);
            zw_reg <= prod30(qz_reg, qw_reg);
            tc_reg <= tc_next;
            td_reg <= tc_reg;
            sq33_reg <= 64'(mag33) * 64'(mag33);
            sq31_reg <= 64'(mag31) * 64'(mag31);
            st_reg[0]   <= td_reg;
            sq_reg[0].n <= sq33_reg + sq31_reg;
            sq_reg[0].r <= 64'h0;
            cs_reg[0]   <= prep_next;
            out_data_reg   <= out_data_next;
            out_gimbal_reg <= cs_reg[CORDIC_STEPS].gimbal;
        end
    end

    // one result bit per stage, stage k uses the trial bit 2^(64-2k)
    genvar k;
    generate
        for (k = 1; k <= NSQ; k++)
        begin : g_sqrt
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
            sqrt_t nxt;
            always_comb
            begin
                if (sq_reg[k-1].n >= sq_reg[k-1].r + BIT)
                begin
                    nxt.n = sq_reg[k-1].n - (sq_reg[k-1].r + BIT);
                    nxt.r = (sq_reg[k-1].r >> 1) + BIT;
                end
                else
                begin
                    nxt.n = sq_reg[k-1].n;
                    nxt.r = sq_reg[k-1].r >> 1;
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[k] <= 1'b0;
                else if (en)
                    sv_reg[k] <= sv_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_reg[k] <= nxt;
                    st_reg[k] <= st_reg[k-1];
                end
            end
        end

        for (k = 1; k <= CORDIC_STEPS; k++)
        begin : g_cordic
            cstage_t nxt;
            always_comb
            begin
                nxt.pitch  = lane_step(cs_reg[k-1].pitch, k - 1);
                nxt.yaw    = lane_step(cs_reg[k-1].yaw, k - 1);
                nxt.roll   = lane_step(cs_reg[k-1].roll, k - 1);
                nxt.gimbal = cs_reg[k-1].gimbal;
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cv_reg[k] <= 1'b0;
                else if (en)
                    cv_reg[k] <= cv_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    cs_reg[k] <= nxt;
            end
        end
    endgenerate

    logic [31:0] cy;
    terms_t tq;
    logic gimbal;

    always_comb
    begin
        cy     = sq_reg[NSQ].r[31:0];
        tq     = st_reg[NSQ];
        gimbal = cy <= 32'(gimbal_threshold_reg);
        prep_next.gimbal = gimbal;
        prep_next.pitch  = lane_prep(-CORDIC_W'(tq.m32), CORDIC_W'({1'b0, cy}));
        prep_next.yaw    = lane_prep(CORDIC_W'(tq.m31), CORDIC_W'(tq.m33));
        if (gimbal)
            prep_next.roll = lane_prep(-CORDIC_W'(tq.m21), CORDIC_W'(tq.m11));
        else
            prep_next.roll = lane_prep(CORDIC_W'(tq.m12), CORDIC_W'(tq.m22));
        out_data_next[15:0]  = lane_angle(cs_reg[CORDIC_STEPS].pitch);
        out_data_next[31:16] = cs_reg[CORDIC_STEPS].gimbal ? 16'h0
                                                          : lane_angle(cs_reg[CORDIC_STEPS].yaw);
        out_data_next[47:32] = lane_angle(cs_reg[CORDIC_STEPS].roll);
    end

    assign m_axis_tvalid   = out_v_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_gimbal_reg;

    // yaw is forced to zero whenever gimbal lock is flagged
    a_gimbal_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:16] == 16'h0)
        else $error("yaw not zero under gimbal lock");

    // a stall holds the item in the square root output stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en && sv_reg[NSQ] |=> sv_reg[NSQ] && $stable(sq_reg[NSQ].r))
        else $error("square root stage changed during stall");

    // a zero magnitude always counts as gimbal lock
    a_zero_cy: assert property (@(posedge clk) disable iff (!rst_n)
        en && sv_reg[NSQ] && sq_reg[NSQ].r == 64'h0 |=> cs_reg[0].gimbal)
        else $error("zero cy without gimbal lock");

endmodule
